[sv/frr_pkg.sv]
// shared types, codes and constants of the framed reply receiver
package frr_pkg;

  // frame bytes and checksum mask
  localparam logic [7:0]  START_BYTE = 8'hDD;
  localparam logic [7:0]  STOP_BYTE  = 8'h77;
  localparam logic [15:0] SUM_MASK   = 16'hFFFF;

  // request codes
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  // result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // frame end status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CKSUM    = 3'd1;
  localparam logic [2:0] ST_BAD_STOP = 3'd2;
  localparam logic [2:0] ST_DEV_ERR  = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

  // configuration register indexes
  localparam logic CFG_CHECK_DEVICE_STATUS = 1'b0;
  localparam logic CFG_VERIFY_CHECKSUM     = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CMD,
    PH_STATUS,
    PH_LEN,
    PH_PAYLOAD,
    PH_CK_HI,
    PH_CK_LO,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [2:0] frame_status;
    logic [7:0] reply_command;
    logic [7:0] device_status;
    logic [7:0] payload_length;
  } frr_result_t;

endpackage

[sv/frr_parser.sv]
// frame state machine, running checksum and per-byte result logic
module frr_parser import frr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept_i,
  input  logic        cmd_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i,
  output logic        res_valid_o,
  output frr_result_t res_o
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_command_r, held_command_nxt;
  logic [7:0]  held_status_r, held_status_nxt;
  logic [7:0]  held_length_r, held_length_nxt;
  logic [7:0]  payload_count_r, payload_count_nxt;
  logic [15:0] running_sum_r, running_sum_nxt;
  logic [15:0] received_ck_r, received_ck_nxt;
  logic        check_dev_r, verify_ck_r;
  logic [15:0] expected_ck;
  logic [15:0] sum_plus_byte;
  logic [2:0]  stop_status;

  assign sum_plus_byte = running_sum_r + {8'd0, rx_byte_i};
  assign expected_ck   = SUM_MASK - running_sum_r + 16'd1;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept_i) begin
      if (cmd_i == CMD_TIMEOUT) begin
        phase_nxt = PH_IDLE;
      end else begin
        unique case (phase_r)
          PH_IDLE:    if (rx_byte_i == START_BYTE) phase_nxt = PH_CMD;
          PH_CMD:     phase_nxt = PH_STATUS;
          PH_STATUS:  phase_nxt = PH_LEN;
          PH_LEN:     phase_nxt = (rx_byte_i == 8'd0) ? PH_CK_HI : PH_PAYLOAD;
          PH_PAYLOAD: begin
            if (payload_count_r + 8'd1 == held_length_r) phase_nxt = PH_CK_HI;
          end
          PH_CK_HI:   phase_nxt = PH_CK_LO;
          PH_CK_LO:   phase_nxt = PH_STOP;
          PH_STOP:    phase_nxt = PH_IDLE;
          default:    phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // frame end status, by priority
  always_comb begin
    if (rx_byte_i != STOP_BYTE) begin
      stop_status = ST_BAD_STOP;
    end else if (check_dev_r && held_status_r != 8'd0) begin
      stop_status = ST_DEV_ERR;
    end else if (verify_ck_r && expected_ck != received_ck_r) begin
      stop_status = ST_CKSUM;
    end else begin
      stop_status = ST_OK;
    end
  end

  // held fields and result
  always_comb begin
    held_command_nxt  = held_command_r;
    held_status_nxt   = held_status_r;
    held_length_nxt   = held_length_r;
    payload_count_nxt = payload_count_r;
    running_sum_nxt   = running_sum_r;
    received_ck_nxt   = received_ck_r;
    res_valid_o       = 1'b0;
    res_o.kind           = KIND_FRAME;
    res_o.data_byte      = 8'd0;
    res_o.byte_index     = 8'd0;
    res_o.frame_status   = ST_OK;
    res_o.reply_command  = held_command_r;
    res_o.device_status  = held_status_r;
    res_o.payload_length = held_length_r;
    if (accept_i) begin
      if (cmd_i == CMD_TIMEOUT) begin
        res_valid_o        = (phase_r != PH_IDLE);
        res_o.frame_status = ST_TIMEOUT;
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            if (rx_byte_i == START_BYTE) begin
              held_command_nxt  = 8'd0;
              held_status_nxt   = 8'd0;
              held_length_nxt   = 8'd0;
              payload_count_nxt = 8'd0;
              running_sum_nxt   = 16'd0;
              received_ck_nxt   = 16'd0;
            end
          end
          PH_CMD:    held_command_nxt = rx_byte_i;
          PH_STATUS: begin
            held_status_nxt = rx_byte_i;
            running_sum_nxt = {8'd0, rx_byte_i};
          end
          PH_LEN: begin
            held_length_nxt   = rx_byte_i;
            running_sum_nxt   = sum_plus_byte;
            payload_count_nxt = 8'd0;
          end
          PH_PAYLOAD: begin
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_DATA;
            res_o.data_byte   = rx_byte_i;
            res_o.byte_index  = payload_count_r;
            running_sum_nxt   = sum_plus_byte;
            payload_count_nxt = payload_count_r + 8'd1;
          end
          PH_CK_HI: received_ck_nxt = {rx_byte_i, 8'd0};
          PH_CK_LO: received_ck_nxt = {received_ck_r[15:8], rx_byte_i};
          PH_STOP: begin
            res_valid_o        = 1'b1;
            res_o.frame_status = stop_status;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      held_command_r  <= 8'd0;
      held_status_r   <= 8'd0;
      held_length_r   <= 8'd0;
      payload_count_r <= 8'd0;
      running_sum_r   <= 16'd0;
      received_ck_r   <= 16'd0;
      check_dev_r     <= 1'b1;
      verify_ck_r     <= 1'b1;
    end else begin
      phase_r         <= phase_nxt;
      held_command_r  <= held_command_nxt;
      held_status_r   <= held_status_nxt;
      held_length_r   <= held_length_nxt;
      payload_count_r <= payload_count_nxt;
      running_sum_r   <= running_sum_nxt;
      received_ck_r   <= received_ck_nxt;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_CHECK_DEVICE_STATUS: check_dev_r <= cfg_data_i;
          CFG_VERIFY_CHECKSUM:     verify_ck_r <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  a_data_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_o && res_o.kind == KIND_DATA |-> res_o.frame_status == ST_OK)
    else $error("payload result carries a frame status");

  a_timeout_idles: assert property (@(posedge clk) disable iff (!rst_n)
    accept_i && cmd_i == CMD_TIMEOUT |=> phase_r == PH_IDLE)
    else $error("timeout did not abort the frame");

  a_zero_len_skip: assert property (@(posedge clk) disable iff (!rst_n)
    accept_i && cmd_i == CMD_BYTE && phase_r == PH_LEN && rx_byte_i == 8'd0
    |=> phase_r == PH_CK_HI)
    else $error("zero length frame entered payload");

  a_result_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_o |-> accept_i)
    else $error("result without an accepted request");

endmodule

[sv/frr_out_reg.sv]
// result register that decouples the result channel from the input side
module frr_out_reg import frr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_i,
  input  frr_result_t res_i,
  input  logic        out_stall_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  output frr_result_t out_res_o
);

  logic        valid_r, valid_nxt;
  frr_result_t res_r;
  logic        open_slot;

  // register may take a new result when empty or being drained this cycle
  assign open_slot  = !valid_r || !out_stall_i;
  assign in_stall_o = !open_slot;

  always_comb begin
    valid_nxt = valid_r;
    if (open_slot) valid_nxt = push_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (open_slot && push_i) res_r <= res_i;
  end

  assign out_valid_o = valid_r;
  assign out_res_o   = res_r;

endmodule

[sv/framed_reply_receiver_top.sv]
// top level of the framed reply receiver
//
// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    in_cmd, in_rx_byte
// out_      output     out_valid / out_stall  out_kind, out_data_byte, out_byte_index,
//                                             out_frame_status, out_reply_command,
//                                             out_device_status, out_payload_length
// cfg_      input      cfg_we                 cfg_index, cfg_data
//
// one request is taken per cycle while in_stall is low; its result, if any, shows at the outputs
// the cycle after acceptance, set by the single result register
// the parser state updates in the accept cycle, so back to back requests chain
// reset (rst_n low, synchronous) sends the parser idle, clears the held
// frame fields and sets both checks on
// in_stall rises only while a result waits and out_stall holds it
module framed_reply_receiver_top import frr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_rx_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_byte_index,
  output logic [2:0] out_frame_status,
  output logic [7:0] out_reply_command,
  output logic [7:0] out_device_status,
  output logic [7:0] out_payload_length,
  // configuration writes
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data
);

  logic        accept;
  logic        res_valid;
  frr_result_t res;
  frr_result_t out_res;

  // a request is taken when valid and the result register has room
  assign accept = in_valid && !in_stall;

  // state machine and checksum datapath
  frr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_i    (accept),
    .cmd_i       (in_cmd),
    .rx_byte_i   (in_rx_byte),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register toward the consumer
  frr_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_res_o   (out_res)
  );

  // unpack the registered result onto the field ports
  assign out_kind           = out_res.kind;
  assign out_data_byte      = out_res.data_byte;
  assign out_byte_index     = out_res.byte_index;
  assign out_frame_status   = out_res.frame_status;
  assign out_reply_command  = out_res.reply_command;
  assign out_device_status  = out_res.device_status;
  assign out_payload_length = out_res.payload_length;

endmodule
